// ----- sv/pvpcd_pkg.sv -----
// Package for the pneumatic valve and pump command decoder: action codes, modes and types.
package pvpcd_pkg;

  // Action characters (ASCII).
  localparam logic [7:0] ACT_STOP         = 8'h21; // '!'
  localparam logic [7:0] ACT_INFLATE      = 8'h2B; // '+'
  localparam logic [7:0] ACT_VACUUM       = 8'h2D; // '-'
  localparam logic [7:0] ACT_HALF_INFLATE = 8'h70; // 'p'
  localparam logic [7:0] ACT_HALF_VACUUM  = 8'h6E; // 'n'
  localparam logic [7:0] ACT_RELEASE      = 8'h5E; // '^'
  localparam logic [7:0] ACT_OPEN_PORTS   = 8'h6F; // 'o'
  localparam logic [7:0] ACT_CLOSE_PORTS  = 8'h63; // 'c'
  localparam logic [7:0] ACT_POWER_OFF    = 8'h66; // 'f'
  localparam logic [7:0] ACT_RED_LED      = 8'h72; // 'r'
  localparam logic [7:0] ACT_BLUE_LED     = 8'h62; // 'b'
  localparam logic [7:0] ACT_QUERY        = 8'h3F; // '?'

  // Hardware modes.
  localparam logic [2:0] MODE_GENERAL         = 3'd0;
  localparam logic [2:0] MODE_INFLATE_SERIES  = 3'd1;
  localparam logic [2:0] MODE_INFLATE_PARALLEL = 3'd2;
  localparam logic [2:0] MODE_VACUUM_SERIES   = 3'd3;
  localparam logic [2:0] MODE_VACUUM_PARALLEL = 3'd4;

  localparam int unsigned NUM_PORTS = 5;

  // Held drives of the controller, plus the per-item query flag.
  typedef struct packed {
    logic                 inlet_valve;
    logic                 outlet_valve;
    logic                 pump_one;
    logic                 pump_two;
    logic [NUM_PORTS-1:0] port_valves;
    logic                 red_led;
    logic                 blue_led;
    logic                 power_off;
    logic                 pressure_request;
  } drive_t;

endpackage

// ----- sv/pneumatic_valve_pump_command_decoder_unit.sv -----
// Top level of the pneumatic valve and pump command decoder.
//
//  Channel   Direction  Handshake             Payload
//  in_       item in    in_valid / in_stall   in_action_code[7:0], in_port_mask[7:0]
//  out_      item out   out_valid / out_stall inlet, outlet, pumps, port_valves[4:0],
//                                              LEDs, power_off, pressure_request
//  cfg_      write      cfg_valid / cfg_ready cfg_wdata[2:0] (hardware mode)
//
// Each command passes through two registers: an input register and the result
// register, which also holds the controller's drive state. An accepted item moves from
// the input register into the result register once the result register is free, and
// its result is then shown on the outputs. One command is taken every cycle
// while the result side keeps up. The rate is set by the single decode between the
// two registers. Reset is synchronous and active low; it clears the drives, the
// mode and both valid flags. A stall on the result side holds the result register,
// and the input register then fills and raises in_stall.
module pneumatic_valve_pump_command_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  // Command input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_action_code,
  input  logic [7:0] in_port_mask,
  // Result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_inlet_valve,
  output logic       out_outlet_valve,
  output logic       out_pump_one,
  output logic       out_pump_two,
  output logic [4:0] out_port_valves,
  output logic       out_red_led,
  output logic       out_blue_led,
  output logic       out_power_off,
  output logic       out_pressure_request,
  // Configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_wdata
);
  import pvpcd_pkg::*;

  // Hardware mode register.
  logic [2:0] mode_r;

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_act_r;
  logic [7:0] s1_mask_r;

  // Result register. Apart from the query flag it is also the controller state,
  // which only moves on when a command is written into it, so it is always the
  // state after the last command shown.
  logic   out_valid_r;
  drive_t res_r;
  drive_t res_nxt;

  logic out_free;
  logic s1_move;
  logic in_accept;

  // The result register can take a new item when it is empty or being taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GENERAL;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_act_r  <= in_action_code;
      s1_mask_r <= in_port_mask;
    end
  end

  // Stop: close both valves, stop both pumps, close the masked ports.
  function automatic drive_t halt_all(drive_t s, logic [NUM_PORTS-1:0] m);
    drive_t r;
    r              = s;
    r.inlet_valve  = 1'b0;
    r.outlet_valve = 1'b0;
    r.pump_one     = 1'b0;
    r.pump_two     = 1'b0;
    r.port_valves  = s.port_valves & ~m;
    return r;
  endfunction

  logic [NUM_PORTS-1:0] m5;
  logic                 m5_any;
  logic                 mode_gen;
  logic                 mode_infl;
  logic                 mode_vac;

  assign m5        = s1_mask_r[NUM_PORTS-1:0];
  assign m5_any    = |m5;
  assign mode_gen  = (mode_r == MODE_GENERAL);
  assign mode_infl = (mode_r == MODE_INFLATE_SERIES) || (mode_r == MODE_INFLATE_PARALLEL);
  assign mode_vac  = (mode_r == MODE_VACUUM_SERIES) || (mode_r == MODE_VACUUM_PARALLEL);

  // Command decode: next drive state from the current state and the held command.
  always_comb begin
    res_nxt                  = res_r;
    res_nxt.pressure_request = 1'b0;
    unique case (s1_act_r)
      ACT_STOP: begin
        res_nxt = halt_all(res_nxt, m5);
      end
      ACT_INFLATE: begin
        res_nxt = halt_all(res_nxt, m5);
        if ((mode_gen || mode_infl) && m5_any) begin
          res_nxt.inlet_valve = 1'b1;
          res_nxt.port_valves = m5;
          res_nxt.pump_one    = 1'b1;
          res_nxt.pump_two    = !mode_gen;
        end
      end
      ACT_HALF_INFLATE: begin
        res_nxt = halt_all(res_nxt, m5);
        if (mode_infl && m5_any) begin
          res_nxt.inlet_valve = 1'b1;
          res_nxt.port_valves = m5;
          res_nxt.pump_one    = 1'b1;
        end
      end
      ACT_VACUUM: begin
        res_nxt = halt_all(res_nxt, m5);
        if ((mode_gen || mode_vac) && m5_any) begin
          res_nxt.outlet_valve = 1'b1;
          res_nxt.port_valves  = m5;
          res_nxt.pump_two     = 1'b1;
          res_nxt.pump_one     = !mode_gen;
        end
      end
      ACT_HALF_VACUUM: begin
        res_nxt = halt_all(res_nxt, m5);
        if (mode_vac && m5_any) begin
          res_nxt.outlet_valve = 1'b1;
          res_nxt.port_valves  = m5;
          res_nxt.pump_one     = 1'b1;
        end
      end
      ACT_RELEASE: begin
        res_nxt = halt_all(res_nxt, m5);
        if (m5_any) begin
          res_nxt.port_valves = m5;
          // General and inflation set-ups vent through the outlet, all others through the inlet.
          if (mode_gen || mode_infl) begin
            res_nxt.outlet_valve = 1'b1;
          end else begin
            res_nxt.inlet_valve = 1'b1;
          end
        end
      end
      ACT_OPEN_PORTS: begin
        res_nxt.port_valves = res_r.port_valves | m5;
      end
      ACT_CLOSE_PORTS: begin
        res_nxt.port_valves = res_r.port_valves & ~m5;
      end
      ACT_POWER_OFF: begin
        if (s1_mask_r == ACT_POWER_OFF) begin
          res_nxt.power_off = 1'b1;
        end
      end
      ACT_RED_LED: begin
        res_nxt.red_led = |s1_mask_r;
      end
      ACT_BLUE_LED: begin
        res_nxt.blue_led = |s1_mask_r;
      end
      ACT_QUERY: begin
        if (s1_mask_r != ACT_QUERY) begin
          res_nxt.inlet_valve  = 1'b0;
          res_nxt.outlet_valve = 1'b0;
          res_nxt.pump_one     = 1'b0;
          res_nxt.pump_two     = 1'b0;
          res_nxt.port_valves  = m5;
        end
        res_nxt.pressure_request = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      if (s1_move) begin
        res_r <= res_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_inlet_valve      = res_r.inlet_valve;
  assign out_outlet_valve     = res_r.outlet_valve;
  assign out_pump_one         = res_r.pump_one;
  assign out_pump_two         = res_r.pump_two;
  assign out_port_valves      = res_r.port_valves;
  assign out_red_led          = res_r.red_led;
  assign out_blue_led         = res_r.blue_led;
  assign out_power_off        = res_r.power_off;
  assign out_pressure_request = res_r.pressure_request;

endmodule

// ----- sv/pvpcd_checker.sv -----
// Port-level checker for the command decoder, bound to the top level.
module pvpcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_action_code,
  input logic [7:0] in_port_mask,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_inlet_valve,
  input logic       out_outlet_valve,
  input logic       out_pump_one,
  input logic       out_pump_two,
  input logic [4:0] out_port_valves,
  input logic       out_red_led,
  input logic       out_blue_led,
  input logic       out_power_off,
  input logic       out_pressure_request
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_port_valves)
      && $stable(out_pressure_request) && $stable(out_inlet_valve)
      && $stable(out_outlet_valve) && $stable(out_pump_one) && $stable(out_pump_two)
      && $stable(out_red_led) && $stable(out_blue_led) && $stable(out_power_off))
    else $error("stalled result changed");

  // A stalled command stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_action_code) && $stable(in_port_mask))
    else $error("stalled command changed");

  // The input side only stalls when a result is waiting and being held off.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Power-off is latched until reset.
  a_power_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_power_off |=> out_power_off)
    else $error("power-off released without reset");

  // A pump never runs with both valves shut.
  a_pump_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pump_one || out_pump_two) |-> out_inlet_valve || out_outlet_valve)
    else $error("pump running with no open valve");

endmodule

bind pneumatic_valve_pump_command_decoder_unit pvpcd_checker u_pvpcd_checker (.*);
